@@ rtl/lemniscate_tracking_controller_defines.svh @@
// Assertion macros for the lemniscate tracking controller.
// Included by the RTL files that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef LEMNISCATE_TRACKING_CONTROLLER_DEFINES_SVH
`define LEMNISCATE_TRACKING_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while reset is asserted.
`define LTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while reset is asserted.
`define LTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LTC_ASSERT_IMP(lbl, ante, cons, msg)
`define LTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/ltc_pkg.sv @@
// Shared constants, types and helper functions of the lemniscate tracking controller.
// No dependencies; used by ltc_cordic, ltc_arith and the top level.
package ltc_pkg;

	localparam int DEF_FRACTION_BITS = 16;
	localparam int DEF_CORDIC_STEPS  = 16;
	localparam int ATAN_ENTRIES      = 24;

	localparam logic [31:0] CORDIC_K_Q30 = 32'd652032875;
	localparam logic [31:0] SQRT2_Q30    = 32'd1518500250;

	// Operand and result widths of the shared arithmetic unit and the CORDIC.
	localparam int DIV_BITS   = 60;
	localparam int DVS_W      = 34;
	localparam int MUL_B_W    = 32;
	localparam int MUL_DIGIT  = 8;
	localparam int MUL_DIGITS = MUL_B_W / MUL_DIGIT;
	localparam int CRD_W      = 36;

	// Input opcodes.
	localparam logic [1:0] OP_ODOM  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// Register indexes.
	localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
	localparam logic [2:0] REG_GAIN        = 3'd1;
	localparam logic [2:0] REG_LOOKAHEAD   = 3'd2;
	localparam logic [2:0] REG_PHASE_STEP  = 3'd3;
	localparam logic [2:0] REG_TICK_PERIOD = 3'd4;

	localparam logic [23:0] RST_AMPLITUDE   = 24'd196608;
	localparam logic [23:0] RST_GAIN        = 24'd65536;
	localparam logic [19:0] RST_LOOKAHEAD   = 20'd3277;
	localparam logic [30:0] RST_PHASE_STEP  = 31'd6835653;
	localparam logic [19:0] RST_TICK_PERIOD = 20'd6554;

	typedef struct packed {
		logic start;
		logic is_div;
	} ltc_ar_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ltc_unit_sts_t;

	// Arctangent of 2^-i as a binary angle, 2^32 per turn.
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/ltc_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle, in rotation mode (sine and cosine)
// or vectoring mode (atan2). Depends on ltc_pkg.
module ltc_cordic #(
	parameter int CORDIC_STEPS = ltc_pkg::DEF_CORDIC_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                vec,
	input  logic [31:0]                         angle,
	input  logic signed [ltc_pkg::CRD_W-1:0]    vin_x,
	input  logic signed [ltc_pkg::CRD_W-1:0]    vin_y,
	output ltc_pkg::ltc_unit_sts_t              sts,
	output logic signed [ltc_pkg::CRD_W-1:0]    out_x,
	output logic signed [ltc_pkg::CRD_W-1:0]    out_y,
	output logic [31:0]                         out_z
);

	localparam int IW = $clog2(ltc_pkg::ATAN_ENTRIES);

	logic                              busy_q, done_q;
	logic [IW-1:0]                     i_q;
	logic                              vec_q, flip_q;
	logic signed [ltc_pkg::CRD_W-1:0]  x_q, y_q, dx, dy, x_n, y_n;
	logic signed [32:0]                z_q, z_n, at;
	logic                              dir, last, flip_in;
	logic [31:0]                       ang_in;

	assign last    = (i_q == IW'(CORDIC_STEPS - 1));
	assign flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
	assign ang_in  = flip_in ? (angle + 32'h8000_0000) : angle;

	always_comb begin
		dx  = y_q >>> i_q;
		dy  = x_q >>> i_q;
		at  = {1'b0, ltc_pkg::atan_entry(5'(i_q))};
		dir = vec_q ? (y_q > 0) : !z_q[32];
		if (dir) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
		// Vectoring runs the opposite way round.
		if (vec_q) begin
			x_n = dir ? x_q + dx : x_q - dx;
			y_n = dir ? y_q - dy : y_q + dy;
			z_n = dir ? z_q + at : z_q - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= vec;
			if (vec) begin
				flip_q <= 1'b0;
				if (vin_x < 0) begin
					x_q <= -vin_x;
					y_q <= -vin_y;
					z_q <= 33'sh0_8000_0000;
				end else begin
					x_q <= vin_x;
					y_q <= vin_y;
					z_q <= '0;
				end
			end else begin
				flip_q <= flip_in;
				x_q    <= ltc_pkg::CRD_W'(ltc_pkg::CORDIC_K_Q30);
				y_q    <= '0;
				z_q    <= {ang_in[31], ang_in};
			end
		end else if (busy_q) begin
			z_q <= z_n;
			if (last && flip_q) begin
				x_q <= -x_n;
				y_q <= -y_n;
			end else begin
				x_q <= x_n;
				y_q <= y_n;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign out_x    = x_q;
	assign out_y    = y_q;
	assign out_z    = z_q[31:0];

endmodule

@@ rtl/ltc_arith.sv @@
// Shared multi-cycle arithmetic unit: signed multiply by 8-bit digits of the second
// operand, and signed-by-positive division one quotient bit a cycle. Depends on ltc_pkg.
module ltc_arith (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ltc_pkg::ltc_ar_req_t    req,
	input  logic signed [63:0]      op_a,
	input  logic signed [63:0]      op_b,
	output ltc_pkg::ltc_unit_sts_t  sts,
	output logic signed [63:0]      result
);

	localparam int DB = ltc_pkg::DIV_BITS;
	localparam int DW = ltc_pkg::DVS_W;
	localparam int MD = ltc_pkg::MUL_DIGIT;

	logic                   busy_q, done_q, div_q;
	logic [5:0]             cnt_q;
	logic                   last;
	logic signed [63:0]     ma_q, acc_q, acc_n, res_q, mag;
	logic [ltc_pkg::MUL_B_W-1:0] mb_q;
	logic signed [MD:0]     digit;
	logic signed [72:0]     pp;
	logic                   neg_q;
	logic [DB-1:0]          quo_q, quo_n;
	logic [DW-1:0]          dvs_q, rem_q, rem_n;
	logic [DW:0]            trial;

	assign last = div_q ? (cnt_q == 6'(DB - 1)) : (cnt_q == 6'(ltc_pkg::MUL_DIGITS - 1));
	assign mag  = op_a[63] ? -op_a : op_a;

	always_comb begin
		// Only the top digit of the multiplier operand carries the sign.
		if (cnt_q == 6'(ltc_pkg::MUL_DIGITS - 1)) begin
			digit = {mb_q[MD-1], mb_q[MD-1:0]};
		end else begin
			digit = {1'b0, mb_q[MD-1:0]};
		end
		pp    = ma_q * digit;
		acc_n = acc_q + pp[63:0];
		trial = {rem_q, quo_q[DB-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_n = DW'(trial - {1'b0, dvs_q});
			quo_n = {quo_q[DB-2:0], 1'b1};
		end else begin
			rem_n = trial[DW-1:0];
			quo_n = {quo_q[DB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			ma_q  <= op_a;
			mb_q  <= op_b[ltc_pkg::MUL_B_W-1:0];
			acc_q <= '0;
			neg_q <= op_a[63];
			quo_q <= mag[DB-1:0];
			rem_q <= '0;
			dvs_q <= op_b[DW-1:0];
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (last) begin
					res_q <= neg_q ? -{{(64-DB){1'b0}}, quo_n} : {{(64-DB){1'b0}}, quo_n};
				end
			end else begin
				acc_q <= acc_n;
				ma_q  <= ma_q <<< MD;
				mb_q  <= mb_q >> MD;
				if (last) begin
					res_q <= acc_n;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = res_q;

endmodule

@@ rtl/lemniscate_tracking_controller.sv @@
// Top level of the lemniscate tracking controller.
// Depends on ltc_pkg, ltc_cordic, ltc_arith and lemniscate_tracking_controller_defines.svh.

// A unicycle robot is steered along a lemniscate of Bernoulli by feedback linearization.
// Items on the slave stream carry an opcode in tuser: odometry stores the robot position and
// the yaw of its orientation quaternion, start zeroes the curve phase and arms the block,
// stop disarms it and returns one item of zero speeds, and a control tick (while armed)
// returns one item with the forward speed and turn rate and advances the phase. The block
// takes one item at a time and drops s_tready while it works: one small sequencer drives a
// shared CORDIC (one micro-rotation a cycle), and a shared multiply/divide unit (an 8-bit
// digit of the multiplier a cycle, one quotient bit a cycle). A control tick runs four
// CORDIC passes, 21 multiplies and nine 60-bit divisions, and the divisions take most
// of its time. A result may wait in the output register while the next item is taken.
// The user must write configuration registers through the cfg port only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high and writes
// to unused indexes are dropped.
module lemniscate_tracking_controller #(
	parameter int FRACTION_BITS = ltc_pkg::DEF_FRACTION_BITS,
	parameter int CORDIC_STEPS  = ltc_pkg::DEF_CORDIC_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input items.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // pos_x[31:0], pos_y[63:32], quat_x, quat_y, quat_z, quat_w
	input  logic [1:0]   s_tuser,  // opcode
	// Result items.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // linear_speed[31:0], angular_rate[63:32]
	// Configuration writes.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	`include "lemniscate_tracking_controller_defines.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	// Program steps of the sequencer.
	localparam logic [4:0] S_HCS = 5'd0;   // heading sine and cosine
	localparam logic [4:0] S_OFX = 5'd1;   // lookahead offset x
	localparam logic [4:0] S_OFY = 5'd2;   // lookahead offset y
	localparam logic [4:0] S_AMP = 5'd3;   // amplitude times root two
	localparam logic [4:0] S_CRV = 5'd4;   // sine and cosine of the curve phase
	localparam logic [4:0] S_SS  = 5'd5;
	localparam logic [4:0] S_CS  = 5'd6;
	localparam logic [4:0] S_NX  = 5'd7;
	localparam logic [4:0] S_PX  = 5'd8;
	localparam logic [4:0] S_NY  = 5'd9;
	localparam logic [4:0] S_PY  = 5'd10;
	localparam logic [4:0] S_GX  = 5'd11;
	localparam logic [4:0] S_FX  = 5'd12;
	localparam logic [4:0] S_GY  = 5'd13;
	localparam logic [4:0] S_FY  = 5'd14;
	localparam logic [4:0] S_V1  = 5'd15;
	localparam logic [4:0] S_V2  = 5'd16;
	localparam logic [4:0] S_W1  = 5'd17;
	localparam logic [4:0] S_W2  = 5'd18;
	localparam logic [4:0] S_W   = 5'd19;
	localparam logic [4:0] S_Q1  = 5'd20;  // odometry: yaw numerator and denominator terms
	localparam logic [4:0] S_Q2  = 5'd21;
	localparam logic [4:0] S_Q3  = 5'd22;
	localparam logic [4:0] S_Q4  = 5'd23;
	localparam logic [4:0] S_ATN = 5'd24;  // odometry: atan2

	localparam logic [1:0] CRV_LAST = 2'd2;
	localparam int         CW       = ltc_pkg::CRD_W;

	// Control and architectural state.
	logic [1:0]          state_q;
	logic [4:0]          step_q;
	logic [1:0]          kidx_q;
	logic                running_q;
	logic [31:0]         phase_q;
	logic signed [31:0]  robot_x_q, robot_y_q;
	logic [15:0]         heading_q;
	logic                m_tvalid_q;
	logic [63:0]         m_tdata_q;
	logic [23:0]         amplitude_q, gain_q;
	logic [19:0]         lookahead_q, tick_period_q;
	logic [30:0]         phase_step_q;

	// Working registers of one item.
	logic signed [15:0]  qx_q, qy_q, qz_q, qw_q;
	logic signed [31:0]  chd_q, shd_q, cc_q, ss_q, cs_q;
	logic [32:0]         denom_q;
	logic [24:0]         amp2_q;
	logic signed [21:0]  ofx_q, ofy_q;
	logic signed [27:0]  px_q [3];
	logic signed [27:0]  py_q [3];
	logic signed [63:0]  acc_q, gx_q;
	logic signed [31:0]  rx_q, ry_q, vout_q, wout_q;
	logic signed [CW-1:0] sy_q, cy_q;

	logic                    accept, wb, out_free;
	logic [19:0]             d_eff, dt_eff;
	logic [31:0]             crv_angle;
	logic signed [63:0]      ex, ey, op_a, op_b;
	logic                    use_co, co_vec;
	logic [31:0]             co_angle;
	ltc_pkg::ltc_ar_req_t    ar_req;
	ltc_pkg::ltc_unit_sts_t  ar_sts, co_sts;
	logic signed [63:0]      ar_res;
	logic signed [CW-1:0]    co_x, co_y;
	logic [31:0]             co_z;
	logic [31:0]             hd_round;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign wb        = (state_q == ST_WAIT) && (ar_sts.done || co_sts.done);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// A zero lookahead or period counts as one LSB.
	assign d_eff  = (lookahead_q == '0) ? 20'd1 : lookahead_q;
	assign dt_eff = (tick_period_q == '0) ? 20'd1 : tick_period_q;

	always_comb begin
		case (kidx_q)
			2'd0:    crv_angle = phase_q;
			2'd1:    crv_angle = phase_q + {1'b0, phase_step_q};
			default: crv_angle = phase_q - {1'b0, phase_step_q};
		endcase
	end

	// Error from the lookahead point to the curve point.
	assign ex = 64'(px_q[0]) - (64'(robot_x_q) + 64'(ofx_q));
	assign ey = 64'(py_q[0]) - (64'(robot_y_q) + 64'(ofy_q));

	// Operand selection for the step being issued.
	always_comb begin
		op_a          = '0;
		op_b          = '0;
		use_co        = 1'b0;
		co_vec        = 1'b0;
		co_angle      = '0;
		ar_req.is_div = 1'b0;
		case (step_q)
			S_HCS: begin
				use_co   = 1'b1;
				co_angle = {heading_q, 16'h0000};
			end
			S_OFX: begin
				op_a = 64'(chd_q);
				op_b = 64'(d_eff);
			end
			S_OFY: begin
				op_a = 64'(shd_q);
				op_b = 64'(d_eff);
			end
			S_AMP: begin
				op_a = 64'(amplitude_q);
				op_b = 64'(ltc_pkg::SQRT2_Q30);
			end
			S_CRV: begin
				use_co   = 1'b1;
				co_angle = crv_angle;
			end
			S_SS: begin
				op_a = 64'(ss_q);
				op_b = 64'(ss_q);
			end
			S_CS: begin
				op_a = 64'(cc_q);
				op_b = 64'(ss_q);
			end
			S_NX: begin
				op_a = 64'(amp2_q);
				op_b = 64'(cc_q);
			end
			S_NY: begin
				op_a = 64'(amp2_q);
				op_b = 64'(cs_q);
			end
			S_PX, S_PY: begin
				ar_req.is_div = 1'b1;
				op_a          = acc_q;
				op_b          = 64'(denom_q);
			end
			S_GX: begin
				op_a = ex;
				op_b = 64'(gain_q);
			end
			S_GY: begin
				op_a = ey;
				op_b = 64'(gain_q);
			end
			S_FX: begin
				ar_req.is_div = 1'b1;
				op_a          = (64'(px_q[1]) - 64'(px_q[2])) <<< FRACTION_BITS;
				op_b          = 64'({dt_eff, 1'b0});
			end
			S_FY: begin
				ar_req.is_div = 1'b1;
				op_a          = (64'(py_q[1]) - 64'(py_q[2])) <<< FRACTION_BITS;
				op_b          = 64'({dt_eff, 1'b0});
			end
			S_V1: begin
				op_a = 64'(rx_q);
				op_b = 64'(chd_q);
			end
			S_V2: begin
				op_a = 64'(ry_q);
				op_b = 64'(shd_q);
			end
			S_W1: begin
				op_a = 64'(ry_q);
				op_b = 64'(chd_q);
			end
			S_W2: begin
				op_a = 64'(rx_q);
				op_b = 64'(shd_q);
			end
			S_W: begin
				ar_req.is_div = 1'b1;
				op_a          = acc_q <<< FRACTION_BITS;
				op_b          = 64'(d_eff);
			end
			S_Q1: begin
				op_a = 64'(qw_q);
				op_b = 64'(qz_q);
			end
			S_Q2: begin
				op_a = 64'(qx_q);
				op_b = 64'(qy_q);
			end
			S_Q3: begin
				op_a = 64'(qy_q);
				op_b = 64'(qy_q);
			end
			S_Q4: begin
				op_a = 64'(qz_q);
				op_b = 64'(qz_q);
			end
			S_ATN: begin
				use_co = 1'b1;
				co_vec = 1'b1;
			end
			default: begin
				op_a = '0;
			end
		endcase
		ar_req.start = (state_q == ST_ISSUE) && !use_co;
	end

	ltc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.op_a   (op_a),
		.op_b   (op_b),
		.sts    (ar_sts),
		.result (ar_res)
	);

	ltc_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_ISSUE) && use_co),
		.vec    (co_vec),
		.angle  (co_angle),
		.vin_x  (cy_q),
		.vin_y  (sy_q),
		.sts    (co_sts),
		.out_x  (co_x),
		.out_y  (co_y),
		.out_z  (co_z)
	);

	// The heading is the atan2 angle rounded to 16 bits.
	assign hd_round = co_z + 32'h0000_8000;

	// Sequencer, configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= S_HCS;
			kidx_q        <= '0;
			running_q     <= 1'b0;
			phase_q       <= '0;
			robot_x_q     <= '0;
			robot_y_q     <= '0;
			heading_q     <= '0;
			m_tvalid_q    <= 1'b0;
			amplitude_q   <= ltc_pkg::RST_AMPLITUDE;
			gain_q        <= ltc_pkg::RST_GAIN;
			lookahead_q   <= ltc_pkg::RST_LOOKAHEAD;
			phase_step_q  <= ltc_pkg::RST_PHASE_STEP;
			tick_period_q <= ltc_pkg::RST_TICK_PERIOD;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ltc_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data[23:0];
					ltc_pkg::REG_GAIN:        gain_q        <= cfg_data[23:0];
					ltc_pkg::REG_LOOKAHEAD:   lookahead_q   <= cfg_data[19:0];
					ltc_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data;
					ltc_pkg::REG_TICK_PERIOD: tick_period_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			// A new result is loaded as the old one leaves, so the register never holds two.
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							ltc_pkg::OP_ODOM: begin
								robot_x_q <= s_tdata[31:0];
								robot_y_q <= s_tdata[63:32];
								step_q    <= S_Q1;
								state_q   <= ST_ISSUE;
							end
							ltc_pkg::OP_START: begin
								running_q <= 1'b1;
								phase_q   <= '0;
							end
							ltc_pkg::OP_STOP: begin
								running_q <= 1'b0;
								state_q   <= ST_OUT;
							end
							default: begin
								if (running_q) begin
									step_q  <= S_HCS;
									state_q <= ST_ISSUE;
								end
							end
						endcase
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (wb) begin
						case (step_q)
							S_AMP: begin
								kidx_q  <= '0;
								step_q  <= step_q + 1'b1;
								state_q <= ST_ISSUE;
							end
							S_PY: begin
								state_q <= ST_ISSUE;
								if (kidx_q != CRV_LAST) begin
									kidx_q <= kidx_q + 1'b1;
									step_q <= S_CRV;
								end else begin
									step_q <= step_q + 1'b1;
								end
							end
							S_W: begin
								phase_q <= phase_q + {1'b0, phase_step_q};
								state_q <= ST_OUT;
							end
							S_ATN: begin
								heading_q <= hd_round[31:16];
								state_q   <= ST_IDLE;
							end
							default: begin
								step_q  <= step_q + 1'b1;
								state_q <= ST_ISSUE;
							end
						endcase
					end
				end
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers; written when a step's unit finishes, on accepted odometry and stop items, and at output load.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {wout_q, vout_q};
		end
		if (accept && s_tuser == ltc_pkg::OP_ODOM) begin
			qx_q <= s_tdata[79:64];
			qy_q <= s_tdata[95:80];
			qz_q <= s_tdata[111:96];
			qw_q <= s_tdata[127:112];
		end
		if (accept && s_tuser == ltc_pkg::OP_STOP) begin
			vout_q <= '0;
			wout_q <= '0;
		end
		if (wb) begin
			case (step_q)
				S_HCS: begin
					chd_q <= co_x[31:0];
					shd_q <= co_y[31:0];
				end
				S_OFX: ofx_q <= 22'(ar_res >>> 30);
				S_OFY: ofy_q <= 22'(ar_res >>> 30);
				S_AMP: amp2_q <= ar_res[54:30];
				S_CRV: begin
					cc_q <= co_x[31:0];
					ss_q <= co_y[31:0];
				end
				S_SS:  denom_q <= 33'((ar_res >>> 30) + 64'sd1073741824);
				S_CS:  cs_q <= 32'(ar_res >>> 30);
				S_NX, S_NY, S_V1, S_W1, S_Q1, S_Q3: acc_q <= ar_res;
				S_PX:  px_q[kidx_q] <= ar_res[27:0];
				S_PY:  py_q[kidx_q] <= ar_res[27:0];
				S_GX, S_GY: gx_q <= ar_res >>> FRACTION_BITS;
				S_FX:  rx_q <= ltc_pkg::sat32(gx_q + ar_res);
				S_FY:  ry_q <= ltc_pkg::sat32(gx_q + ar_res);
				S_V2:  vout_q <= ltc_pkg::sat32((acc_q + ar_res) >>> 30);
				S_W2:  acc_q <= (acc_q - ar_res) >>> 30;
				S_W:   wout_q <= ltc_pkg::sat32(ar_res);
				S_Q2:  sy_q <= CW'((acc_q + ar_res) <<< 1);
				S_Q4:  cy_q <= CW'(64'sd268435456 - ((acc_q + ar_res) <<< 1));
				default: ;
			endcase
		end
	end

	`LTC_ASSERT_IMP(a_done_in_wait, ar_sts.done || co_sts.done, state_q == ST_WAIT,
		"unit finished while the sequencer was not waiting")
	`LTC_ASSERT_IMP(a_one_unit, 1'b1, !(ar_sts.busy && co_sts.busy),
		"both shared units busy at once")
	`LTC_ASSERT_NXT(a_stop_result, accept && s_tuser == ltc_pkg::OP_STOP,
		!running_q && state_q == ST_OUT, "stop did not disarm and queue a result")
	`LTC_ASSERT_NXT(a_tick_ends, wb && step_q == S_W, state_q == ST_OUT,
		"tick finished without queueing a result")
	`LTC_ASSERT_NXT(a_out_load, state_q == ST_OUT && out_free, m_tvalid_q,
		"result not loaded into the output register")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for lemniscate_tracking_controller: random and directed items with a
// behavioral steering predictor; depends only on ltc_pkg and the RTL top level.
module tb;

	localparam int         TRACK_FB     = 16;
	localparam int         TRACK_STEPS  = 16;
	localparam int         STALL_LIMIT  = 20000;
	localparam int         DRAIN_CYCLES = 1000;
	localparam logic [2:0] REG_UNUSED   = 3'd7;

	// One input item as the sender sees it.
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
	} odo_item_t;

	// One speed command as the block should return it.
	typedef struct {
		logic signed [31:0] speed;
		logic signed [31:0] rate;
	} cmd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = ltc_pkg::OP_ODOM;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = ltc_pkg::REG_AMPLITUDE;
	logic [30:0]  cfg_data = '0;

	always #10 clk = ~clk;

	lemniscate_tracking_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers and of the tracking state.
	logic [23:0]        amp_r   = ltc_pkg::RST_AMPLITUDE;
	logic [23:0]        gain_r  = ltc_pkg::RST_GAIN;
	logic [19:0]        look_r  = ltc_pkg::RST_LOOKAHEAD;
	logic [30:0]        step_r  = ltc_pkg::RST_PHASE_STEP;
	logic [19:0]        period_r = ltc_pkg::RST_TICK_PERIOD;
	bit                 armed   = 1'b0;
	logic [31:0]        phase   = '0;
	logic signed [31:0] bot_x   = '0;
	logic signed [31:0] bot_y   = '0;
	logic [15:0]        heading = '0;

	odo_item_t pending_items[$];
	cmd_t      pending_cmds[$];
	odo_item_t cur_item;

	int tx_idle_pct = 10;
	int rx_idle_pct = 70;
	int fail_count = 0;
	int items_taken = 0;
	int cmds_seen = 0;
	int ticks_steered = 0;
	int settings_run = 0;
	int quiet_cycles = 0;

	// Appends one expected command at the tail of the queue.
	function automatic void add_cmd(input cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Appends one item at the tail of the sender's queue.
	function automatic void add_item(input odo_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Rotation-mode CORDIC: cosine and sine of a binary angle, Q2.30.
	function automatic void trig_of(input logic [31:0] ang, output longint c, output longint s);
		logic [31:0] a;
		bit          flip;
		longint      x, y, z, dx, dy;
		a = ang;
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (flip) a = a + 32'h8000_0000;
		z = longint'(signed'(a));
		x = longint'(ltc_pkg::CORDIC_K_Q30);
		y = 0;
		for (int i = 0; i < TRACK_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ltc_pkg::atan_entry(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(ltc_pkg::atan_entry(5'(i)));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	// Vectoring-mode CORDIC: binary angle of the vector (x, y).
	function automatic logic [31:0] bearing_of(input longint y_in, input longint x_in);
		logic [31:0] z;
		longint      x, y, dx, dy;
		x = x_in;
		y = y_in;
		z = '0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (int i = 0; i < TRACK_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z = z + ltc_pkg::atan_entry(5'(i));
			end else begin
				x -= dx; y += dy; z = z - ltc_pkg::atan_entry(5'(i));
			end
		end
		return z;
	endfunction

	// Point of the lemniscate of Bernoulli at a given phase.
	function automatic void lemniscate_at(input logic [31:0] ph, output longint px,
			output longint py);
		longint c, s, denom, amp2, cs;
		trig_of(ph, c, s);
		denom = ((s * s) >>> 30) + (longint'(1) << 30);
		amp2 = (longint'(amp_r) * longint'(ltc_pkg::SQRT2_Q30)) >>> 30;
		cs = (c * s) >>> 30;
		px = (amp2 * c) / denom;
		py = (amp2 * cs) / denom;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Updates the tracking state for one accepted item and queues the command it causes.
	function automatic void steer_model(input odo_item_t it);
		longint      c, s, lx, ly, ax, ay, bx, by, ex, ey, rx, ry, v, w, dt, d, sy, cy;
		longint      one;
		logic [31:0] hb;
		cmd_t        cmd;
		one = longint'(1) << TRACK_FB;
		case (it.op)
			ltc_pkg::OP_ODOM: begin
				sy = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
				cy = (longint'(1) << 28) - 2 * (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
				bot_x = it.pos_x;
				bot_y = it.pos_y;
				hb = bearing_of(sy, cy) + 32'h8000;
				heading = hb[31:16];
			end
			ltc_pkg::OP_START: begin
				armed = 1'b1;
				phase = '0;
			end
			ltc_pkg::OP_STOP: begin
				armed = 1'b0;
				cmd.speed = '0;
				cmd.rate = '0;
				add_cmd(cmd);
			end
			default: begin
				// A tick while disarmed is dropped without a command.
				if (armed) begin
					dt = (period_r != 0) ? longint'(period_r) : 1;
					d = (look_r != 0) ? longint'(look_r) : 1;
					trig_of({heading, 16'h0}, c, s);
					lemniscate_at(phase, lx, ly);
					lemniscate_at(phase + {1'b0, step_r}, ax, ay);
					lemniscate_at(phase - {1'b0, step_r}, bx, by);
					// Error from the lookahead point to the curve, plus the
					// central-difference velocity of the curve.
					ex = lx - (longint'(bot_x) + ((d * c) >>> 30));
					ey = ly - (longint'(bot_y) + ((d * s) >>> 30));
					rx = clamp32(((longint'(gain_r) * ex) >>> TRACK_FB)
						+ ((ax - bx) * one) / (2 * dt));
					ry = clamp32(((longint'(gain_r) * ey) >>> TRACK_FB)
						+ ((ay - by) * one) / (2 * dt));
					v = clamp32((rx * c + ry * s) >>> 30);
					w = clamp32((((ry * c - rx * s) >>> 30) * one) / d);
					cmd.speed = v[31:0];
					cmd.rate = w[31:0];
					add_cmd(cmd);
					phase = phase + {1'b0, step_r};
					ticks_steered++;
				end
			end
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what,
			$signed(got), $signed(want));
		fail_count++;
	endtask

	// Sender: presents the next queued item, with random gaps between items.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				steer_model(cur_item);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_item.op;
					s_tdata <= {cur_item.qw, cur_item.qz, cur_item.qy, cur_item.qx,
						cur_item.pos_y, cur_item.pos_x};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure and a field-by-field check of each command.
	always @(posedge clk) begin
		cmd_t want;
		if (m_tvalid && m_tready) begin
			cmds_seen++;
			if (pending_cmds.size() == 0) begin
				report("unexpected command, linear_speed", m_tdata[31:0], '0);
			end else begin
				want = pending_cmds.pop_front();
				if (m_tdata[31:0] !== want.speed) report("linear_speed", m_tdata[31:0], want.speed);
				if (m_tdata[63:32] !== want.rate) report("angular_rate", m_tdata[63:32], want.rate);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Watchdog on cycles in which no handshake of any kind completes.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ltc_pkg::REG_AMPLITUDE:   amp_r = val[23:0];
			ltc_pkg::REG_GAIN:        gain_r = val[23:0];
			ltc_pkg::REG_LOOKAHEAD:   look_r = val[19:0];
			ltc_pkg::REG_PHASE_STEP:  step_r = val;
			ltc_pkg::REG_TICK_PERIOD: period_r = val[19:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [30:0] amp, input logic [30:0] g, input logic [30:0] la,
			input logic [30:0] ps, input logic [30:0] tp);
		write_reg(ltc_pkg::REG_AMPLITUDE, amp);
		write_reg(ltc_pkg::REG_GAIN, g);
		write_reg(ltc_pkg::REG_LOOKAHEAD, la);
		write_reg(ltc_pkg::REG_PHASE_STEP, ps);
		write_reg(ltc_pkg::REG_TICK_PERIOD, tp);
		settings_run++;
	endtask

	// Waits until the block has returned every command and has had time to
	// finish any item that gives none, so that registers may be written.
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || pending_cmds.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_odom(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [15:0] qx, input logic signed [15:0] qy,
			input logic signed [15:0] qz, input logic signed [15:0] qw);
		odo_item_t it;
		it.op = ltc_pkg::OP_ODOM;
		it.pos_x = x; it.pos_y = y;
		it.qx = qx; it.qy = qy; it.qz = qz; it.qw = qw;
		add_item(it);
	endtask

	// Non-odometry items carry random payload bits, which the block must ignore.
	task automatic push_op(input logic [1:0] op);
		odo_item_t it;
		it.op = op;
		it.pos_x = $urandom; it.pos_y = $urandom;
		it.qx = $urandom; it.qy = $urandom; it.qz = $urandom; it.qw = $urandom;
		add_item(it);
	endtask

	function automatic logic signed [15:0] rand_quat();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// Mostly well-formed traffic: odometry fixes interleaved with ticks, with an
	// occasional start, stop, and positions far off the curve.
	task automatic push_random(input int n);
		int                 r;
		logic signed [31:0] x, y;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				push_op(ltc_pkg::OP_START);
			end else if (r < 12) begin
				push_op(ltc_pkg::OP_STOP);
			end else if (r < 55) begin
				if ($urandom_range(0, 9) < 8) begin
					x = $signed($urandom_range(0, 655360)) - 327680;
					y = $signed($urandom_range(0, 655360)) - 327680;
				end else begin
					x = $urandom;
					y = $urandom;
				end
				if ($urandom_range(0, 9) < 3) begin
					// Pure yaw, sometimes the zero quaternion.
					if ($urandom_range(0, 9) == 0) push_odom(x, y, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
					else push_odom(x, y, 16'sd0, 16'sd0, rand_quat(), rand_quat());
				end else begin
					push_odom(x, y, rand_quat(), rand_quat(), rand_quat(), rand_quat());
				end
			end else begin
				push_op(ltc_pkg::OP_TICK);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		push_op(ltc_pkg::OP_TICK);  // disarmed tick is ignored
		push_op(ltc_pkg::OP_STOP);  // stop while disarmed still answers
		push_op(ltc_pkg::OP_START);
		push_odom(32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		push_op(ltc_pkg::OP_TICK);
		push_odom(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
		push_op(ltc_pkg::OP_TICK);
		push_odom(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
		push_op(ltc_pkg::OP_TICK);
		push_odom(32'sd196608, -32'sd65536, -16'sd16384, 16'sd0, 16'sd0, 16'sd0);
		push_op(ltc_pkg::OP_TICK);
		push_odom(-32'sd1, 32'sd1, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
		push_op(ltc_pkg::OP_TICK);
		push_op(ltc_pkg::OP_START); // restart resets the phase
		push_op(ltc_pkg::OP_TICK);
		push_odom(32'sd0, 32'sd0, 16'sd0, 16'sd16384, -16'sd16384, 16'sd16384);
		push_op(ltc_pkg::OP_TICK);
		push_op(ltc_pkg::OP_STOP);
		push_op(ltc_pkg::OP_TICK);
		push_op(ltc_pkg::OP_START);
		push_op(ltc_pkg::OP_TICK);
		push_random(460);
		drain();

		// Large amplitude and gain, largest phase step, shortest lookahead and period: saturation.
		write_all(31'd8388608, 31'd8388608, 31'd1, 31'h7FFF_FFFF, 31'd1);
		push_op(ltc_pkg::OP_START);
		push_random(300);
		drain();

		// Zero registers but the phase step, including the zero lookahead and zero period cases.
		tx_idle_pct = 70;
		rx_idle_pct = 10;
		write_all(31'd0, 31'd0, 31'd0, 31'd1, 31'd0);
		push_op(ltc_pkg::OP_START);
		push_random(300);
		drain();

		write_all(31'd1, 31'($urandom_range(0, 8388608)), 31'd655360,
			31'($urandom_range(1, 31'h7FFF_FFFF)), 31'd655360);
		write_reg(REG_UNUSED, 31'($urandom));
		push_op(ltc_pkg::OP_START);
		push_random(300);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_all(31'($urandom_range(0, 8388608)), 31'($urandom_range(0, 8388608)),
			31'($urandom_range(1, 655360)), 31'($urandom_range(1, 31'h7FFF_FFFF)),
			31'($urandom_range(1, 655360)));
		push_op(ltc_pkg::OP_START);
		push_random(300);
		drain();

		write_all(31'($urandom_range(65536, 327680)), 31'($urandom_range(16384, 262144)),
			31'($urandom_range(1000, 20000)), 31'($urandom_range(1000000, 20000000)),
			31'($urandom_range(1000, 20000)));
		push_op(ltc_pkg::OP_START);
		push_random(300);
		drain();

		$display("Ran %0d items over %0d register settings: %0d steering ticks, %0d commands.",
			items_taken, settings_run, ticks_steered, cmds_seen);
		if (fail_count == 0 && pending_cmds.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
